FILE: sv/evhang_pkg.sv
// ----------------------------------------------------------------------------
// Event loop hang watchdog package
// Command codes, configuration register indexes and fixed constants shared
// by the watchdog logic.
// ----------------------------------------------------------------------------
package evhang_pkg;

	// Width of the command field and of the configuration index.
	localparam int CMD_W = 3;
	localparam int CFG_IDX_W = 2;

	// Event commands carried by each request.
	typedef enum logic [CMD_W-1:0] {
		CMD_CHECK      = 3'd0,
		CMD_GENERAL    = 3'd1,
		CMD_NO_UI      = 3'd2,
		CMD_UI_PENDING = 3'd3,
		CMD_UI         = 3'd4,
		CMD_SUSPEND    = 3'd5
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT   = 2'd0,
		CFG_LAG_THR   = 2'd1,
		CFG_DISABLE   = 2'd2
	} cfg_idx_t;

	// Field widths fixed by the interface.
	localparam int CFG_W = 16;
	localparam int LAG_W = 32;
	localparam int NOW_W = 32;
	localparam int CNT_W = 2;

	// Fixed constants of the watchdog.
	localparam logic [CFG_W-1:0] LAG_THR_RESET = 16'd50;
	localparam logic [9:0] MS_PER_SECOND = 10'd1000;
	localparam logic [LAG_W-1:0] LAG_MAX = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0] COUNT_MAX = 2'd3;
	localparam logic [CNT_W-1:0] HANG_PASS = 2'd2;

	// Width of (timeout + 1) * 1000, at most 65536000.
	localparam int LIMIT_W = 27;

endpackage

FILE: sv/event_loop_hang_watchdog_unit.sv
// ----------------------------------------------------------------------------
// Event loop hang watchdog unit
// Two-pass hang detector for a stamped event stream, with UI lag accounting.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | command, ui_pending, now_ms
//  out     | out_valid / out_stall  | hang, lag_report, lag_ms, checks_unchanged
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One result per request. A request is held in the input stage and is
// evaluated against the watchdog state as it moves to the output register,
// and a new request is taken every cycle unless in_stall is high.
// The input stage can fill while a result waits, so one request may enter while
// the output is stalled; in_stall rises only when both stages are full.
// Reset clears state, flags, timeout and disable; lag threshold resets to 50.
// The configuration port is always ready.
module event_loop_hang_watchdog_unit #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Event requests.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [evhang_pkg::CMD_W-1:0]      command,
	input  logic                              ui_pending,
	input  logic [evhang_pkg::NOW_W-1:0]      now_ms,
	// Results.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hang,
	output logic                              lag_report,
	output logic [evhang_pkg::LAG_W-1:0]      lag_ms,
	output logic [evhang_pkg::CNT_W-1:0]      checks_unchanged,
	// Configuration writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [evhang_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [evhang_pkg::CFG_W-1:0]      cfg_data
);
	import evhang_pkg::*;

	localparam int TW = TIME_WIDTH;
	localparam int WIDE_W = (TW > NOW_W) ? TW : NOW_W;
	localparam int SUM_W = ((TW > LAG_W) ? TW : LAG_W) + 1;
	localparam int CMP_W = (TW > LIMIT_W) ? TW : LIMIT_W;

	// Configuration registers.
	logic [CFG_W-1:0] timeout_q;
	logic [CFG_W-1:0] lag_thr_q;
	logic             disabled_q;

	// Watchdog state.
	logic [TW-1:0]    activity_q;
	logic [TW-1:0]    previous_q;
	logic [CNT_W-1:0] count_q;
	logic [LAG_W-1:0] lag_q;

	// Input stage.
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic             pending_s1;
	logic [TW-1:0]    now_s1;

	// Output register.
	logic             out_valid_q;
	logic             hang_q;
	logic             report_q;
	logic [LAG_W-1:0] lag_out_q;
	logic [CNT_W-1:0] count_out_q;

	logic             in_accept;
	logic             advance;
	logic [WIDE_W-1:0] now_wide;

	// Next-state values computed from the input stage.
	cmd_t             cmd_eff;
	logic [TW-1:0]    stamp;
	logic             stamp_same;
	logic [CNT_W-1:0] count_inc;
	logic [TW-1:0]    elapsed;
	logic [LIMIT_W-1:0] limit_ms;
	logic [TW-1:0]    delta;
	logic [SUM_W-1:0] lag_sum;
	logic [LAG_W-1:0] lag_added;
	logic [TW-1:0]    activity_d;
	logic [TW-1:0]    previous_d;
	logic [CNT_W-1:0] count_d;
	logic [LAG_W-1:0] lag_d;
	logic             hang_d;
	logic             report_d;
	logic [LAG_W-1:0] lag_out_d;

	// Handshake control.
	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign now_wide = WIDE_W'(now_ms);

	// Configuration writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= '0;
			lag_thr_q <= LAG_THR_RESET;
			disabled_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TIMEOUT: timeout_q <= cfg_data;
				CFG_LAG_THR: lag_thr_q <= cfg_data;
				CFG_DISABLE: disabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1 <= cmd_t'(command);
			pending_s1 <= ui_pending;
			now_s1 <= now_wide[TW-1:0];
		end
	end

	// Shared terms: effective stamp, elapsed time and lag accumulation.
	always_comb begin
		stamp = activity_q;
		if (activity_q != '0 && now_s1 < activity_q) begin
			stamp = TW'(1);
		end
		stamp_same = (stamp != '0) && (stamp == previous_q) && (timeout_q != '0);
		count_inc = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + CNT_W'(1);
		elapsed = now_s1 - stamp;
		// More than T whole seconds means at least (T + 1) * 1000 ms.
		limit_ms = (LIMIT_W'(timeout_q) + LIMIT_W'(1)) * LIMIT_W'(MS_PER_SECOND);
		delta = now_s1 - activity_q;
		lag_sum = SUM_W'(lag_q) + SUM_W'(delta);
		if (activity_q == '0) begin
			lag_added = lag_q;
		end else if (lag_sum > SUM_W'(LAG_MAX)) begin
			lag_added = LAG_MAX;
		end else begin
			lag_added = lag_sum[LAG_W-1:0];
		end
	end

	// Command decode and state update.
	always_comb begin
		cmd_eff = cmd_s1;
		if (cmd_s1 == CMD_GENERAL) begin
			cmd_eff = pending_s1 ? CMD_UI_PENDING : CMD_NO_UI;
		end
		activity_d = activity_q;
		previous_d = previous_q;
		count_d = count_q;
		lag_d = lag_q;
		hang_d = 1'b0;
		report_d = 1'b0;
		lag_out_d = '0;
		case (cmd_eff)
			CMD_CHECK: begin
				if (stamp_same) begin
					count_d = count_inc;
					if (count_inc == HANG_PASS) begin
						hang_d = (CMP_W'(elapsed) >= CMP_W'(limit_ms)) && !disabled_q;
					end
				end else begin
					previous_d = stamp;
					count_d = '0;
				end
			end
			CMD_NO_UI: begin
				lag_d = '0;
				activity_d = now_s1;
			end
			CMD_UI_PENDING: begin
				lag_d = lag_added;
				activity_d = now_s1;
			end
			CMD_UI: begin
				activity_d = now_s1;
				if (lag_added > LAG_W'(lag_thr_q)) begin
					report_d = 1'b1;
					lag_out_d = lag_added;
				end
				lag_d = '0;
			end
			CMD_SUSPEND: begin
				activity_d = '0;
			end
			default: ;
		endcase
	end

	// Watchdog state registers, updated as a request leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			activity_q <= '0;
			previous_q <= '0;
			count_q <= '0;
			lag_q <= '0;
		end else if (advance) begin
			activity_q <= activity_d;
			previous_q <= previous_d;
			count_q <= count_d;
			lag_q <= lag_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			hang_q <= hang_d;
			report_q <= report_d;
			lag_out_q <= lag_out_d;
			count_out_q <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign hang = hang_q;
	assign lag_report = report_q;
	assign lag_ms = lag_out_q;
	assign checks_unchanged = count_out_q;

	// A hang is only flagged on the second unchanged check.
	a_hang_on_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hang_q |-> count_out_q == HANG_PASS)
		else $error("hang flagged outside the second pass");

	// A check never reports lag and UI activity never flags a hang.
	a_hang_xor_lag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hang_q && report_q))
		else $error("hang and lag report in one result");

	// Reported lag is zero unless a report is made.
	a_lag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !report_q |-> lag_out_q == '0)
		else $error("lag value without a report");

	// A request leaving the input stage always produces a result.
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("request lost between stages");

	// The state counter and the reported count agree after each result.
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> count_out_q == count_q)
		else $error("reported count differs from state");

endmodule

FILE: bench/tb_event_loop_hang_watchdog_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Event loop hang watchdog unit testbench
// Feeds stamped check, activity and suspend requests through the watchdog
// under several register settings and random idling on both channels. Each
// result is compared with a prediction kept in step with every accepted
// request.
// ----------------------------------------------------------------------------
module tb_event_loop_hang_watchdog_unit;
	import evhang_pkg::*;

	// Command codes that the watchdog must ignore.
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 16;
	localparam int PHASES = 6;
	localparam int PHASE_EVENTS = 170;

	// One result as the watchdog reports it.
	typedef struct packed {
		logic             hang;
		logic             lag_report;
		logic [LAG_W-1:0] lag_ms;
		logic [CNT_W-1:0] checks_unchanged;
	} verdict_t;

	// Tracks the watchdog state and holds the verdicts still owed by the block.
	class hang_ledger;
		logic [CFG_W-1:0] timeout_s = '0;
		logic [CFG_W-1:0] lag_thr = LAG_THR_RESET;
		logic             disabled = 1'b0;
		logic [NOW_W-1:0] stamp = '0;
		logic [NOW_W-1:0] seen_stamp = '0;
		logic [CNT_W-1:0] same_count = '0;
		logic [LAG_W-1:0] lag_sum = '0;
		verdict_t         results_due[$];
		int               failures = 0;

		function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_TIMEOUT: timeout_s = data;
				CFG_LAG_THR: lag_thr = data;
				CFG_DISABLE: disabled = data[0];
				default: ;
			endcase
		endfunction

		// Adds the time since the last stamp to the UI lag, saturating.
		function void accrue_lag(logic [NOW_W-1:0] now);
			logic [LAG_W:0] sum;
			if (stamp != '0) begin
				sum = {1'b0, lag_sum} + {1'b0, now - stamp};
				lag_sum = sum[LAG_W] ? LAG_MAX : sum[LAG_W-1:0];
			end
		endfunction

		// Applies one accepted request and queues the verdict it must produce.
		function void note_event(logic [CMD_W-1:0] cmd, logic pending,
				logic [NOW_W-1:0] now);
			logic [CMD_W-1:0] op;
			logic [NOW_W-1:0] ts;
			logic [NOW_W-1:0] secs;
			verdict_t v;
			v = '0;
			op = cmd;
			if (op == CMD_GENERAL) begin
				op = pending ? CMD_UI_PENDING : CMD_NO_UI;
			end
			case (op)
				CMD_CHECK: begin
					// A stamp from the future counts as the earliest valid time.
					ts = stamp;
					if (ts != '0 && now < ts) begin
						ts = 1;
					end
					if (ts != '0 && ts == seen_stamp && timeout_s != '0) begin
						if (same_count != COUNT_MAX) begin
							same_count++;
						end
						if (same_count == HANG_PASS) begin
							secs = (now - ts) / MS_PER_SECOND;
							if (secs > timeout_s && !disabled) begin
								v.hang = 1'b1;
							end
						end
					end else begin
						seen_stamp = ts;
						same_count = '0;
					end
				end
				CMD_NO_UI, CMD_UI_PENDING, CMD_UI: begin
					if (op == CMD_NO_UI) begin
						lag_sum = '0;
					end else begin
						accrue_lag(now);
					end
					stamp = now;
					if (op == CMD_UI) begin
						if (lag_sum > lag_thr) begin
							v.lag_report = 1'b1;
							v.lag_ms = lag_sum;
						end
						lag_sum = '0;
					end
				end
				CMD_SUSPEND: begin
					stamp = '0;
				end
				default: ;
			endcase
			v.checks_unchanged = same_count;
			results_due.insert(results_due.size(), v);
		endfunction

		function void compare(string field, logic [LAG_W-1:0] want,
				logic [LAG_W-1:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %0h, actual %0h", field, want, got);
				failures++;
			end
		endfunction

		// Matches one accepted result against the oldest verdict owed.
		function void check_result(verdict_t got);
			verdict_t want;
			if (results_due.size() == 0) begin
				$error("result with none outstanding: hang %0b lag_report %0b %s %0h %s %0d",
					got.hang, got.lag_report, "lag_ms", got.lag_ms,
					"count", got.checks_unchanged);
				failures++;
			end else begin
				want = results_due.pop_front();
				compare("hang", want.hang, got.hang);
				compare("lag_report", want.lag_report, got.lag_report);
				compare("lag_ms", want.lag_ms, got.lag_ms);
				compare("checks_unchanged", want.checks_unchanged, got.checks_unchanged);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [CMD_W-1:0] command = CMD_CHECK;
	logic             ui_pending = 1'b0;
	logic [NOW_W-1:0] now_ms = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             hang;
	logic             lag_report;
	logic [LAG_W-1:0] lag_ms;
	logic [CNT_W-1:0] checks_unchanged;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TIMEOUT;
	logic [CFG_W-1:0] cfg_data = '0;

	hang_ledger       ledger = new;
	logic             idle_on = 1'b1;
	logic [NOW_W-1:0] clock_ms = '0;
	int               events_sent = 0;
	int               quiet_cycles = 0;

	logic [CFG_W-1:0] phase_timeout [PHASES] = '{16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd0, 16'd4};
	logic [CFG_W-1:0] phase_thr [PHASES] = '{16'd0, 16'hFFFF, 16'd50, 16'd200, 16'd50, 16'd50};
	logic             phase_off [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

	event_loop_hang_watchdog_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.ui_pending       (ui_pending),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.hang             (hang),
		.lag_report       (lag_report),
		.lag_ms           (lag_ms),
		.checks_unchanged (checks_unchanged),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// Free-running clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check every result taken from the block.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			ledger.check_result(verdict_t'{hang, lag_report, lag_ms, checks_unchanged});
		end
	end

	// End the run if no request moves on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("event_loop_hang_watchdog_unit verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: stall in random bursts while idling is enabled.
	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Presents one request, with an optional idle burst first, and waits for it.
	task automatic send_event(logic [CMD_W-1:0] cmd, logic pending, logic [NOW_W-1:0] now);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		ui_pending <= pending;
		now_ms <= now;
		do @(posedge clk); while (in_stall);
		ledger.note_event(cmd, pending, now);
		if (cmd <= CMD_SUSPEND) begin
			events_sent++;
		end
	endtask

	// Holds off new requests until every owed result has arrived.
	task automatic await_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.results_due.size() != 0);
	endtask

	// Leaves cfg_valid high so that back-to-back writes need no gap.
	task automatic write_register(cfg_idx_t idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		ledger.set_register(idx, data);
	endtask

	task automatic apply_settings(logic [CFG_W-1:0] timeout, logic [CFG_W-1:0] thr, logic off);
		write_register(CFG_TIMEOUT, timeout);
		write_register(CFG_LAG_THR, thr);
		write_register(CFG_DISABLE, CFG_W'(off));
		cfg_valid <= 1'b0;
	endtask

	// An activity followed by a run of checks spaced around the timeout.
	task automatic watch_scene();
		int span;
		int checks;
		span = (ledger.timeout_s > 8 ? 8 : int'(ledger.timeout_s)) + 2;
		clock_ms += $urandom_range(1, 500);
		send_event(CMD_W'($urandom_range(1, 4)), 1'($urandom_range(0, 1)), clock_ms);
		checks = $urandom_range(2, 5);
		repeat (checks) begin
			if ($urandom_range(0, 9) == 0) begin
				clock_ms += $urandom_range(0, 100_000_000);
			end else begin
				clock_ms += $urandom_range(0, span * 1000);
			end
			send_event(CMD_CHECK, 1'($urandom_range(0, 1)), clock_ms);
		end
	endtask

	// One loose request: mostly steady time, some noise and stale stamps.
	task automatic random_event();
		int r;
		logic [NOW_W-1:0] now;
		logic [CMD_W-1:0] cmd;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			clock_ms += $urandom_range(0, 400);
		end else if (r < 97) begin
			clock_ms += $urandom_range(500, 12000);
		end else if (r < 99) begin
			clock_ms += $urandom_range(0, 100_000_000);
		end else begin
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
		end
		now = clock_ms;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			now = $urandom();
		end else if (r < 8) begin
			now = clock_ms - $urandom_range(1, 5000);
		end
		r = $urandom_range(0, 99);
		if (r < 40) cmd = CMD_CHECK;
		else if (r < 52) cmd = CMD_GENERAL;
		else if (r < 60) cmd = CMD_NO_UI;
		else if (r < 68) cmd = CMD_UI_PENDING;
		else if (r < 86) cmd = CMD_UI;
		else if (r < 94) cmd = CMD_SUSPEND;
		else if (r < 97) cmd = CMD_SPARE_6;
		else cmd = CMD_SPARE_7;
		send_event(cmd, 1'($urandom_range(0, 1)), now);
	endtask

	task automatic run_phase(int count);
		int target;
		target = events_sent + count;
		clock_ms = $urandom_range(1, 1 << 20);
		while (events_sent < target) begin
			if ($urandom_range(0, 99) < 30) begin
				watch_scene();
			end else begin
				random_event();
			end
		end
	endtask

	// Main sequence: reset, directed cases, then random phases.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_settings(16'd2, LAG_THR_RESET, 1'b0);

		// Idle check, then a hang on the second unchanged check.
		send_event(CMD_CHECK, 1'b0, 32'd0);
		send_event(CMD_UI_PENDING, 1'b0, 32'd1000);
		send_event(CMD_CHECK, 1'b0, 32'd1500);
		send_event(CMD_CHECK, 1'b0, 32'd2500);
		send_event(CMD_CHECK, 1'b0, 32'd4500);
		send_event(CMD_CHECK, 1'b0, 32'd5000);
		// Stamp in the future on a check.
		send_event(CMD_CHECK, 1'b0, 32'd900);
		// General activity both ways, lag above and below the threshold.
		send_event(CMD_GENERAL, 1'b1, 32'd1200);
		send_event(CMD_UI, 1'b0, 32'd1300);
		send_event(CMD_GENERAL, 1'b0, 32'd1400);
		send_event(CMD_UI, 1'b0, 32'd1420);
		// Suspend, then activity while idle adds no lag.
		send_event(CMD_SUSPEND, 1'b1, 32'hFFFF_FFFF);
		send_event(CMD_UI_PENDING, 1'b0, 32'd5000);
		// Lag saturation, reported by UI activity at time zero.
		send_event(CMD_UI_PENDING, 1'b1, 32'hFFFF_FFFF);
		send_event(CMD_UI_PENDING, 1'b0, 32'hFFFF_FFFE);
		send_event(CMD_UI, 1'b0, 32'h0000_0000);
		send_event(CMD_CHECK, 1'b0, 32'd100);
		// Unused commands are ignored.
		send_event(CMD_SPARE_6, 1'b1, 32'h5555_AAAA);
		send_event(CMD_SPARE_7, 1'b0, 32'hAAAA_5555);
		// Wrapped time reads as a stamp in the future.
		send_event(CMD_NO_UI, 1'b0, 32'hFFFF_F000);
		send_event(CMD_CHECK, 1'b1, 32'h0000_1000);
		// Elapsed time equal to the timeout is not a hang.
		send_event(CMD_NO_UI, 1'b0, 32'd10000);
		send_event(CMD_CHECK, 1'b0, 32'd10500);
		send_event(CMD_CHECK, 1'b0, 32'd11000);
		send_event(CMD_CHECK, 1'b0, 32'd12999);

		phase_timeout[PHASES-1] = CFG_W'($urandom_range(1, 8));
		phase_thr[PHASES-1] = CFG_W'($urandom_range(0, 1000));
		phase_off[PHASES-1] = 1'($urandom_range(0, 1));
		for (int p = 0; p < PHASES; p++) begin
			await_drain();
			idle_on = (p != 1 && p != PHASES - 1);
			apply_settings(phase_timeout[p], phase_thr[p], phase_off[p]);
			run_phase(PHASE_EVENTS);
		end

		await_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ledger.failures == 0) begin
			$display("event_loop_hang_watchdog_unit verification clean");
		end else begin
			$display("event_loop_hang_watchdog_unit verification failed");
		end
		$finish;
	end

endmodule
